// ===== rtl/lfpm_pkg.sv =====
`timescale 1ns / 1ps
package lfpm_pkg;

    localparam int COORD_BITS    = 20;
    localparam int FRAC_BITS     = 4;
    localparam int SRC_DIM_BITS  = 13;
    localparam int SRC_REG_BITS  = SRC_DIM_BITS + 1;
    localparam int LEFT_BITS     = COORD_BITS + 1;
    localparam int EDGE_BITS     = COORD_BITS + 2;
    localparam int PROD_BITS     = COORD_BITS + SRC_REG_BITS;
    localparam int STEPS_PER_STG = 2;
    localparam int DIV_STAGES    = (SRC_REG_BITS + STEPS_PER_STG - 1) / STEPS_PER_STG;
    localparam int AXIS_LAT      = DIV_STAGES + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;
    localparam int GCNT_BITS     = $clog2(COORD_BITS + 1);

    localparam logic [COORD_BITS-1:0] ONE_PIXEL  = COORD_BITS'(1) << FRAC_BITS;
    localparam logic [COORD_BITS-1:0] HALF_PIXEL = ONE_PIXEL >> 1;
    localparam logic [SRC_REG_BITS-1:0] SRC_OUT_MAX =
        SRC_REG_BITS'((1 << SRC_DIM_BITS) - 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT  = 3'd5;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [LEFT_BITS-1:0]    left;
        logic [LEFT_BITS-1:0]    top;
        logic [EDGE_BITS-1:0]    right;
        logic [EDGE_BITS-1:0]    bottom;
        logic [COORD_BITS-1:0]   fw;
        logic [COORD_BITS-1:0]   fh;
        logic [SRC_REG_BITS-1:0] src_w;
        logic [SRC_REG_BITS-1:0] src_h;
        logic [SRC_DIM_BITS-1:0] lim_x;
        logic [SRC_DIM_BITS-1:0] lim_y;
        logic                    boxed;
        logic                    valid;
    } t_geo;

endpackage

// ===== rtl/lfpm_axis.sv =====
`timescale 1ns / 1ps
// One axis of the point map: offset * src, then a pipelined restoring divide by len.
module lfpm_axis (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [lfpm_pkg::COORD_BITS-1:0]      i_off,
    input  logic [lfpm_pkg::SRC_REG_BITS-1:0]    i_src,
    input  logic [lfpm_pkg::COORD_BITS-1:0]      i_len,
    output logic [lfpm_pkg::SRC_REG_BITS-1:0]    o_quo
);
    localparam int CB = lfpm_pkg::COORD_BITS;
    localparam int QB = lfpm_pkg::SRC_REG_BITS;
    localparam int PB = lfpm_pkg::PROD_BITS;
    localparam int NS = lfpm_pkg::DIV_STAGES;
    localparam int SP = lfpm_pkg::STEPS_PER_STG;

    logic [PB-1:0] r_prod;
    logic [CB-1:0] r_rem [NS];
    logic [QB-1:0] r_dvd [NS];
    logic [QB-1:0] r_quo [NS];
    logic [CB-1:0] n_rem [NS];
    logic [QB-1:0] n_dvd [NS];
    logic [QB-1:0] n_quo [NS];

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PB'(i_off) * PB'(i_src);
        end
    end

    // divide steps: quotient is known to be below 2^QB, so the top part starts as remainder
    always_comb begin
        logic [CB-1:0] rem;
        logic [QB-1:0] dvd;
        logic [QB-1:0] quo;
        logic [CB:0]   t;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                rem = r_prod[PB-1:QB];
                dvd = r_prod[QB-1:0];
                quo = '0;
            end else begin
                rem = r_rem[s-1];
                dvd = r_dvd[s-1];
                quo = r_quo[s-1];
            end
            for (int j = 0; j < SP; j++) begin
                if (s * SP + j < QB) begin
                    t   = {rem, dvd[QB-1]};
                    dvd = {dvd[QB-2:0], 1'b0};
                    if (t >= {1'b0, i_len}) begin
                        t   = t - {1'b0, i_len};
                        quo = {quo[QB-2:0], 1'b1};
                    end else begin
                        quo = {quo[QB-2:0], 1'b0};
                    end
                    rem = t[CB-1:0];
                end
            end
            n_rem[s] = rem;
            n_dvd[s] = dvd;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                r_rem[s] <= n_rem[s];
                r_dvd[s] <= n_dvd[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

// ===== rtl/lfpm_geom.sv =====
`timescale 1ns / 1ps
// Configuration registers and the fit geometry sequencer (shared serial divider).
module lfpm_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfpm_pkg::t_cfg_wr i_cfg,
    output lfpm_pkg::t_geo    o_geo,
    output logic              o_busy
);
    localparam int CB = lfpm_pkg::COORD_BITS;
    localparam int QB = lfpm_pkg::SRC_REG_BITS;
    localparam int PB = lfpm_pkg::PROD_BITS;
    localparam int NB = lfpm_pkg::GCNT_BITS;

    typedef enum logic [5:0] {
        G_IDLE = 6'b000001,
        G_MUL  = 6'b000010,
        G_SEL  = 6'b000100,
        G_DIV  = 6'b001000,
        G_FIN  = 6'b010000,
        G_EDGE = 6'b100000
    } t_gstate;

    t_gstate         r_state;
    logic [CB-1:0]   r_amx, r_amy, r_aw, r_ah;
    logic [QB-1:0]   r_sw, r_sh;
    logic [PB-1:0]   r_pa, r_pb;
    logic            r_tall;
    logic [QB-1:0]   r_dsr;
    logic [QB-1:0]   r_rem;
    logic [CB-1:0]   r_low;
    logic [CB-1:0]   r_quo;
    logic [NB-1:0]   r_cnt;
    logic [CB-1:0]   r_dw, r_dh;
    lfpm_pkg::t_geo  r_geo;
    logic [QB:0]     n_t;
    logic            n_ge;
    logic            n_zero;

    assign n_t    = {r_rem, r_low[CB-1]};
    assign n_ge   = n_t >= {1'b0, r_dsr};
    assign n_zero = (r_aw == '0) || (r_ah == '0) || (r_sw == '0) || (r_sh == '0);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amx <= '0;
            r_amy <= '0;
            r_aw  <= '0;
            r_ah  <= '0;
            r_sw  <= '0;
            r_sh  <= '0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                lfpm_pkg::REG_AREA_MIN_X:  r_amx <= i_cfg.data[CB-1:0];
                lfpm_pkg::REG_AREA_MIN_Y:  r_amy <= i_cfg.data[CB-1:0];
                lfpm_pkg::REG_AREA_WIDTH:  r_aw  <= i_cfg.data[CB-1:0];
                lfpm_pkg::REG_AREA_HEIGHT: r_ah  <= i_cfg.data[CB-1:0];
                lfpm_pkg::REG_SRC_WIDTH:   r_sw  <= i_cfg.data[QB-1:0];
                lfpm_pkg::REG_SRC_HEIGHT:  r_sh  <= i_cfg.data[QB-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: any write restarts the geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_geo   <= '0;
        end else if (i_cfg.we) begin
            r_state <= G_MUL;
        end else begin
            unique case (r_state)
                G_IDLE: begin
                    r_state <= G_IDLE;
                end
                G_MUL: begin
                    r_state <= G_SEL;
                end
                G_SEL: begin
                    if (n_zero) begin
                        r_geo   <= '0;
                        r_state <= G_IDLE;
                    end else begin
                        r_state <= G_DIV;
                    end
                end
                G_DIV: begin
                    if (r_cnt == NB'(CB - 1)) begin
                        r_state <= G_FIN;
                    end
                end
                G_FIN: begin
                    r_state <= G_EDGE;
                end
                G_EDGE: begin
                    r_geo.left   <= lfpm_pkg::LEFT_BITS'(r_amx) + lfpm_pkg::LEFT_BITS'(r_dw >> 1);
                    r_geo.top    <= lfpm_pkg::LEFT_BITS'(r_amy) + lfpm_pkg::LEFT_BITS'(r_dh >> 1);
                    r_geo.boxed  <= (r_dw > lfpm_pkg::HALF_PIXEL) || (r_dh > lfpm_pkg::HALF_PIXEL);
                    r_geo.valid  <= (r_geo.fw >= lfpm_pkg::ONE_PIXEL)
                                 && (r_geo.fh >= lfpm_pkg::ONE_PIXEL);
                    r_geo.src_w  <= r_sw;
                    r_geo.src_h  <= r_sh;
                    r_geo.lim_x  <= (r_sw - QB'(1) > lfpm_pkg::SRC_OUT_MAX)
                                  ? lfpm_pkg::SRC_DIM_BITS'(lfpm_pkg::SRC_OUT_MAX)
                                  : lfpm_pkg::SRC_DIM_BITS'(r_sw - QB'(1));
                    r_geo.lim_y  <= (r_sh - QB'(1) > lfpm_pkg::SRC_OUT_MAX)
                                  ? lfpm_pkg::SRC_DIM_BITS'(lfpm_pkg::SRC_OUT_MAX)
                                  : lfpm_pkg::SRC_DIM_BITS'(r_sh - QB'(1));
                    // far edges: area origin plus half the margin plus the registered fit size
                    r_geo.right  <= lfpm_pkg::EDGE_BITS'(r_amx)
                                  + lfpm_pkg::EDGE_BITS'(r_dw >> 1)
                                  + lfpm_pkg::EDGE_BITS'(r_geo.fw);
                    r_geo.bottom <= lfpm_pkg::EDGE_BITS'(r_amy)
                                  + lfpm_pkg::EDGE_BITS'(r_dh >> 1)
                                  + lfpm_pkg::EDGE_BITS'(r_geo.fh);
                    r_state      <= G_IDLE;
                end
                default: r_state <= G_IDLE;
            endcase
            if (r_state == G_FIN) begin
                r_geo.fw <= r_tall ? r_quo : r_aw;
                r_geo.fh <= r_tall ? r_ah : r_quo;
            end
        end
    end

    // datapath of the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            G_MUL: begin
                r_pa <= PB'(r_aw) * PB'(r_sh);
                r_pb <= PB'(r_ah) * PB'(r_sw);
            end
            G_SEL: begin
                r_tall <= r_pa > r_pb;
                r_cnt  <= '0;
                r_quo  <= '0;
                if (r_pa > r_pb) begin
                    r_dsr <= r_sh;
                    r_rem <= r_pb[PB-1:CB];
                    r_low <= r_pb[CB-1:0];
                end else begin
                    r_dsr <= r_sw;
                    r_rem <= r_pa[PB-1:CB];
                    r_low <= r_pa[CB-1:0];
                end
            end
            G_DIV: begin
                r_rem <= n_ge ? QB'(n_t - {1'b0, r_dsr}) : n_t[QB-1:0];
                r_quo <= {r_quo[CB-2:0], n_ge};
                r_low <= {r_low[CB-2:0], 1'b0};
                r_cnt <= r_cnt + NB'(1);
            end
            G_FIN: begin
                r_dw <= r_aw - (r_tall ? r_quo : r_aw);
                r_dh <= r_ah - (r_tall ? r_ah : r_quo);
            end
            default: ;
        endcase
    end

    assign o_geo  = r_geo;
    assign o_busy = (r_state != G_IDLE) || i_cfg.we;

endmodule

// ===== rtl/letterbox_fit_point_map.sv =====
`timescale 1ns / 1ps
// Pipeline from input to result valid: hit test, product, 7 divide stages of 2 quotient
// bits each (the per-axis pipelined divider), clamp.
// Throughput: one point per cycle while the output is not stalled. After each
// configuration write the geometry sequencer holds input ready low until it is idle.
// Reset: synchronous active low; control registers clear to 0, the fit reads as invalid.
module letterbox_fit_point_map (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [lfpm_pkg::COORD_BITS-1:0]        i_point_x,
    input  logic [lfpm_pkg::COORD_BITS-1:0]        i_point_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [lfpm_pkg::SRC_DIM_BITS-1:0]      o_mapped_x,
    output logic [lfpm_pkg::SRC_DIM_BITS-1:0]      o_mapped_y,
    output logic                                   o_hit,
    output logic [lfpm_pkg::LEFT_BITS-1:0]         o_fit_left,
    output logic [lfpm_pkg::LEFT_BITS-1:0]         o_fit_top,
    output logic [lfpm_pkg::COORD_BITS-1:0]        o_fit_width,
    output logic [lfpm_pkg::COORD_BITS-1:0]        o_fit_height,
    output logic                                   o_letterboxed,
    output logic                                   o_fit_valid,
    input  logic                                   i_cfg_we,
    input  logic [lfpm_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [lfpm_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    localparam int CB = lfpm_pkg::COORD_BITS;
    localparam int QB = lfpm_pkg::SRC_REG_BITS;
    localparam int DB = lfpm_pkg::SRC_DIM_BITS;
    localparam int EB = lfpm_pkg::EDGE_BITS;
    localparam int NL = lfpm_pkg::AXIS_LAT;

    lfpm_pkg::t_cfg_wr w_cfg;
    lfpm_pkg::t_geo    w_geo;
    logic              w_busy;
    logic              w_en;
    logic [QB-1:0]     w_qx, w_qy;

    logic              r_s1_vld, r_s1_hit;
    logic [CB-1:0]     r_offx, r_offy;
    logic              r_vld [NL];
    logic              r_hit [NL];
    logic              r_out_vld;
    logic              r_out_hit;
    logic [DB-1:0]     r_mx, r_my;
    logic              n_hit;

    assign w_cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    lfpm_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .o_geo   (w_geo),
        .o_busy  (w_busy)
    );

    // whole pipe moves when the output register is free or being drained
    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en && !w_busy;

    // stage 1: inside test and offsets
    assign n_hit = w_geo.valid
                && (EB'(i_point_x) >= EB'(w_geo.left)) && (EB'(i_point_x) < w_geo.right)
                && (EB'(i_point_y) >= EB'(w_geo.top))  && (EB'(i_point_y) < w_geo.bottom);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in_valid && o_in_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_hit <= n_hit;
            r_offx   <= CB'(i_point_x - CB'(w_geo.left));
            r_offy   <= CB'(i_point_y - CB'(w_geo.top));
        end
    end

    lfpm_axis u_axis_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_off (r_offx),
        .i_src (w_geo.src_w),
        .i_len (w_geo.fw),
        .o_quo (w_qx)
    );

    lfpm_axis u_axis_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_off (r_offy),
        .i_src (w_geo.src_h),
        .i_len (w_geo.fh),
        .o_quo (w_qy)
    );

    // valid and hit travel beside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= r_s1_vld;
            for (int k = 1; k < NL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit[0] <= r_s1_hit;
            for (int k = 1; k < NL; k++) begin
                r_hit[k] <= r_hit[k-1];
            end
        end
    end

    // output register: clamp and zero on miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= r_hit[NL-1];
            if (!r_hit[NL-1]) begin
                r_mx <= '0;
                r_my <= '0;
            end else begin
                r_mx <= (w_qx > QB'(w_geo.lim_x)) ? w_geo.lim_x : DB'(w_qx);
                r_my <= (w_qy > QB'(w_geo.lim_y)) ? w_geo.lim_y : DB'(w_qy);
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_mapped_x    = r_mx;
    assign o_mapped_y    = r_my;
    assign o_hit         = r_out_hit;
    assign o_fit_left    = w_geo.left;
    assign o_fit_top     = w_geo.top;
    assign o_fit_width   = w_geo.fw;
    assign o_fit_height  = w_geo.fh;
    assign o_letterboxed = w_geo.boxed;
    assign o_fit_valid   = w_geo.valid;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 9;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int CB           = lfpm_pkg::COORD_BITS;
    localparam int DB           = lfpm_pkg::SRC_DIM_BITS;
    localparam int LB           = lfpm_pkg::LEFT_BITS;
    localparam int IB           = lfpm_pkg::CFG_IDX_BITS;
    localparam int WB           = lfpm_pkg::CFG_DATA_BITS;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } t_point;

    typedef struct packed {
        logic [DB-1:0] mapped_x;
        logic [DB-1:0] mapped_y;
        logic          hit;
        logic [LB-1:0] fit_left;
        logic [LB-1:0] fit_top;
        logic [CB-1:0] fit_width;
        logic [CB-1:0] fit_height;
        logic          letterboxed;
        logic          fit_valid;
    } t_map_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          o_in_ready;
    logic [CB-1:0] point_x = '0;
    logic [CB-1:0] point_y = '0;
    logic          o_out_valid;
    logic          out_ready = 1'b0;
    logic          cfg_we = 1'b0;
    logic [IB-1:0] cfg_idx = '0;
    logic [WB-1:0] cfg_data = '0;
    t_map_result   dut_res;

    // shadow copy of the geometry registers
    longint unsigned sh_min_x, sh_min_y, sh_area_w, sh_area_h, sh_src_w, sh_src_h;

    t_point      pending_points[$];
    t_map_result expected_maps[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stall_go = 0;
    bit          stall_done = 0;
    int          stall_cnt = 0;
    bit          in_fire = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          hits_seen = 0;

    letterbox_fit_point_map u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_point_x    (point_x),
        .i_point_y    (point_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_mapped_x   (dut_res.mapped_x),
        .o_mapped_y   (dut_res.mapped_y),
        .o_hit        (dut_res.hit),
        .o_fit_left   (dut_res.fit_left),
        .o_fit_top    (dut_res.fit_top),
        .o_fit_width  (dut_res.fit_width),
        .o_fit_height (dut_res.fit_height),
        .o_letterboxed(dut_res.letterboxed),
        .o_fit_valid  (dut_res.fit_valid),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // floor-scale an offset into source pixels, clamped to the source and output range
    function automatic longint unsigned scale_axis(longint unsigned offs, longint unsigned len,
                                                   longint unsigned src);
        longint unsigned v, lim;
        v   = (offs * src) / len;
        lim = src - 1;
        if (lim > lfpm_pkg::SRC_OUT_MAX) lim = lfpm_pkg::SRC_OUT_MAX;
        return (v > lim) ? lim : v;
    endfunction

    // letterbox fit of the current geometry plus hit test of one point
    function automatic t_map_result fit_and_map(longint unsigned px, longint unsigned py);
        t_map_result     r;
        longint unsigned fw, fh, dw, dh, lft, tp, one;
        r   = '0;
        one = longint'(lfpm_pkg::ONE_PIXEL);
        if (sh_area_w != 0 && sh_area_h != 0 && sh_src_w != 0 && sh_src_h != 0) begin
            if (sh_area_w * sh_src_h > sh_area_h * sh_src_w) begin
                fh = sh_area_h;
                fw = (sh_area_h * sh_src_w) / sh_src_h;
            end else begin
                fw = sh_area_w;
                fh = (sh_area_w * sh_src_h) / sh_src_w;
            end
            dw  = sh_area_w - fw;
            dh  = sh_area_h - fh;
            lft = sh_min_x + (dw >> 1);
            tp  = sh_min_y + (dh >> 1);
            r.fit_left    = lft[LB-1:0];
            r.fit_top     = tp[LB-1:0];
            r.fit_width   = fw[CB-1:0];
            r.fit_height  = fh[CB-1:0];
            r.letterboxed = (2 * dw > one) || (2 * dh > one);
            r.fit_valid   = (fw >= one) && (fh >= one);
            if (r.fit_valid && px >= lft && py >= tp && px < lft + fw && py < tp + fh) begin
                r.hit      = 1'b1;
                r.mapped_x = DB'(scale_axis(px - lft, fw, sh_src_w));
                r.mapped_y = DB'(scale_axis(py - tp, fh, sh_src_h));
            end
        end
        return r;
    endfunction

    // pick a coordinate biased toward the fitted span and its edges
    function automatic logic [CB-1:0] pick_coord(longint unsigned lo, longint unsigned len);
        int unsigned r;
        r = $urandom_range(9);
        if (len == 0 || r >= 7) return CB'($urandom);
        if (r == 6) begin
            case ($urandom_range(3))
                0: return CB'(lo);
                1: return CB'(lo + len - 1);
                2: return CB'(lo + len);
                default: return CB'(lo - 1);
            endcase
        end
        return CB'(lo + $urandom_range(int'(len - 1)));
    endfunction

    // acceptance sampling, scoreboard and cycle limit
    always @(posedge i_clk) begin
        in_fire = in_valid && o_in_ready && i_rst_n;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (expected_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %p", dut_res);
            end else begin
                t_map_result e;
                e = expected_maps.pop_front();
                if (e.hit) hits_seen++;
                if (e.mapped_x !== dut_res.mapped_x || e.mapped_y !== dut_res.mapped_y ||
                    e.hit !== dut_res.hit || e.fit_left !== dut_res.fit_left ||
                    e.fit_top !== dut_res.fit_top || e.fit_width !== dut_res.fit_width ||
                    e.fit_height !== dut_res.fit_height ||
                    e.letterboxed !== dut_res.letterboxed ||
                    e.fit_valid !== dut_res.fit_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d\n  exp %p\n  got %p", mismatches, e, dut_res);
                end
            end
        end
        if (in_fire) expected_maps.push_back(fit_and_map(point_x, point_y));
    end

    // point driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_point p;
                p = pending_points.pop_front();
                in_valid <= 1'b1;
                point_x  <= p.x;
                point_y  <= p.y;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_go && !stall_done) begin
            out_ready <= 1'b0;
            stall_cnt++;
            if (stall_cnt >= HOLD_CYCLES) stall_done = 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [IB-1:0] idx, input longint unsigned val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= WB'(val);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            lfpm_pkg::REG_AREA_MIN_X:  sh_min_x  = val & 64'hFFFFF;
            lfpm_pkg::REG_AREA_MIN_Y:  sh_min_y  = val & 64'hFFFFF;
            lfpm_pkg::REG_AREA_WIDTH:  sh_area_w = val & 64'hFFFFF;
            lfpm_pkg::REG_AREA_HEIGHT: sh_area_h = val & 64'hFFFFF;
            lfpm_pkg::REG_SRC_WIDTH:   sh_src_w  = val & 64'h3FFF;
            lfpm_pkg::REG_SRC_HEIGHT:  sh_src_h  = val & 64'h3FFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input longint unsigned mx, my, aw, ah, sw, sh);
        write_reg(lfpm_pkg::REG_AREA_MIN_X, mx);
        write_reg(lfpm_pkg::REG_AREA_MIN_Y, my);
        write_reg(lfpm_pkg::REG_AREA_WIDTH, aw);
        write_reg(lfpm_pkg::REG_AREA_HEIGHT, ah);
        write_reg(lfpm_pkg::REG_SRC_WIDTH, sw);
        write_reg(lfpm_pkg::REG_SRC_HEIGHT, sh);
    endtask

    // queue points for one phase, then wait until every result is back
    task automatic run_phase(input int n, input int mode);
        t_map_result g;
        t_point      p;
        g = fit_and_map(0, 0);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 46; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 46; end
            default: begin send_idle_pct = 6; recv_idle_pct = 6; end
        endcase
        for (int i = 0; i < n; i++) begin
            p.x = pick_coord(g.fit_left, g.fit_width);
            p.y = pick_coord(g.fit_top, g.fit_height);
            pending_points.push_back(p);
        end
        while (pending_points.size() > 0 || in_valid || expected_maps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_point p;
        sh_min_x = 0; sh_min_y = 0; sh_area_w = 0; sh_area_h = 0; sh_src_w = 0; sh_src_h = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: field extremes against an invalid fit
        p = '{x: '0, y: '0};              pending_points.push_back(p);
        p = '{x: '1, y: '1};              pending_points.push_back(p);
        p = '{x: 20'h55555, y: 20'hAAAAA}; pending_points.push_back(p);
        run_phase(4, 0);

        // pillarbox, full-range corner, source clamp, sub-pixel fit, zero source, exact fit
        set_geometry(0, 0, 1920 * 16, 1080 * 16, 640, 480);
        run_phase(20, 1);
        set_geometry(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8192, 8192);
        run_phase(20, 2);
        set_geometry(100, 200, 20'hFFFFF, 100, 16383, 1);
        run_phase(20, 3);
        set_geometry(5, 5, 8, 8000, 1, 1);
        run_phase(20, 0);
        set_geometry(0, 0, 1000, 1000, 0, 50);
        run_phase(10, 1);
        set_geometry(16, 32, 160, 160, 1, 1);
        run_phase(20, 2);

        // long receiver hold-off while points keep coming
        set_geometry(1000, 2000, 3200, 2400, 8, 6);
        stall_go = 1;
        run_phase(PHASE_ITEMS, 0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            longint unsigned aw, ah;
            aw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, (ph % 2) ? 20'hFFFFF : 4096);
            ah = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, (ph % 2) ? 20'hFFFFF : 4096);
            set_geometry($urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF), aw, ah,
                         $urandom_range(1, 8192), $urandom_range(1, 8192));
            run_phase(PHASE_ITEMS + 40, ph);
        end

        $display("covered %0d result transactions (%0d hits) over %0d geometry settings",
                 results_seen, hits_seen, RAND_PHASES + 8);
        $display("idle mixes on both channels and one %0d-cycle output hold-off", HOLD_CYCLES);
        if (mismatches == 0 && expected_maps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_maps.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
